### sv/bp12_pkg.sv
`default_nettype none

package bp12_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 256;
   localparam int ADDRESS_BITS_DEFAULT  = 32;
   localparam int BRANCH_ADDR_W         = 32;
   localparam int COUNT_W               = 32;

   // Two-bit counter encodings.
   localparam logic [1:0] CTR_STRONG_NOT_TAKEN = 2'd0;
   localparam logic [1:0] CTR_WEAK_TAKEN       = 2'd2;
   localparam logic [1:0] CTR_STRONG_TAKEN     = 2'd3;

   typedef struct packed {
      logic [BRANCH_ADDR_W-1:0] branch_address;
      logic                     outcome_taken;
   } req_type;

   typedef struct packed {
      logic               entry_known;
      logic               predict_one;
      logic               predict_two;
      logic               correct_one;
      logic               correct_two;
      logic [COUNT_W-1:0] branches_seen;
      logic [COUNT_W-1:0] taken_seen;
      logic [COUNT_W-1:0] not_taken_seen;
      logic [COUNT_W-1:0] hits_one;
      logic [COUNT_W-1:0] misses_one;
      logic [COUNT_W-1:0] hits_two;
      logic [COUNT_W-1:0] misses_two;
   } rsp_type;

   typedef struct packed {
      logic fire;
      logic taken;
      logic known;
      logic correct_one;
      logic correct_two;
   } stats_event_type;

   typedef struct packed {
      logic [COUNT_W-1:0] total;
      logic [COUNT_W-1:0] taken;
      logic [COUNT_W-1:0] not_taken;
      logic [COUNT_W-1:0] hit_one;
      logic [COUNT_W-1:0] miss_one;
      logic [COUNT_W-1:0] hit_two;
      logic [COUNT_W-1:0] miss_two;
   } stats_count_type;

endpackage

`default_nettype wire

### sv/bp12_if.sv
`default_nettype none

interface bp12_req_if;
   logic             valid;
   logic             ready;
   bp12_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bp12_rsp_if;
   logic             valid;
   logic             ready;
   bp12_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/bp12_ram.sv
`default_nettype none

module bp12_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### sv/bp12_stats.sv
`default_nettype none

module bp12_stats (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bp12_pkg::stats_event_type evt,
   output      bp12_pkg::stats_count_type count
);

   bp12_pkg::stats_count_type count_ff;
   bp12_pkg::stats_count_type count_in;

   function automatic logic [bp12_pkg::COUNT_W-1:0] sat_inc(
      input logic [bp12_pkg::COUNT_W-1:0] value
   );
      if (value == '1) begin
         return value;
      end
      return value + bp12_pkg::COUNT_W'(1);
   endfunction

   always_comb begin
      count_in = count_ff;
      if (evt.fire) begin
         count_in.total = sat_inc(count_ff.total);
         if (evt.taken) begin
            count_in.taken = sat_inc(count_ff.taken);
         end else begin
            count_in.not_taken = sat_inc(count_ff.not_taken);
         end
         if (evt.known) begin
            if (evt.correct_one) begin
               count_in.hit_one = sat_inc(count_ff.hit_one);
            end else begin
               count_in.miss_one = sat_inc(count_ff.miss_one);
            end
            if (evt.correct_two) begin
               count_in.hit_two = sat_inc(count_ff.hit_two);
            end else begin
               count_in.miss_two = sat_inc(count_ff.miss_two);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

`default_nettype wire

### sv/branch_predictor_one_and_two_bit_core.sv
`default_nettype none

// Bimodal branch predictor that scores a one-bit last-outcome scheme against a
// two-bit saturating counter. Each request is one resolved branch; the table
// entry it maps to is read from a single block RAM in the cycle the request is
// accepted, and while the request sits in the s1 register the hit check,
// scoring and entry update run; the result lands in the response register when
// s1 can advance. One request is taken every cycle while the response is
// taken or empty; the request passes through the s1 and response registers,
// with a one-entry bypass covering back-to-back requests to the same entry.
// After reset the block clears every table entry in turn, with req ready low.
// TABLE_ENTRIES must be a power of two; the running counts in every response
// include that request and hold at their maximum.
module branch_predictor_one_and_two_bit_core #(
   parameter int TABLE_ENTRIES = bp12_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int ADDRESS_BITS  = bp12_pkg::ADDRESS_BITS_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   bp12_req_if.sink   req_ch,
   bp12_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int TAG_W = (ADDRESS_BITS > IDX_W) ? ADDRESS_BITS - IDX_W : 1;
   localparam int EXT_W = ADDRESS_BITS + IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic             last;
      logic [1:0]       ctr;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   logic             req_fire;
   logic [EXT_W-1:0] req_addr;
   logic [IDX_W-1:0] req_idx;
   logic [TAG_W-1:0] req_tag;

   logic             clr_ff;
   logic [IDX_W-1:0] clr_idx_ff;

   logic             s1_valid_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [TAG_W-1:0] s1_tag_ff;
   logic             s1_taken_ff;
   logic             s1_fire;

   logic             byp_valid_ff;
   logic [IDX_W-1:0] byp_idx_ff;
   entry_type        byp_data_ff;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;

   entry_type        cur;
   entry_type        upd;
   logic             hit;
   logic             p1;
   logic             p2;
   logic             c1;
   logic             c2;

   logic             out_valid_ff;
   logic             out_known_ff;
   logic             out_p1_ff;
   logic             out_p2_ff;
   logic             out_c1_ff;
   logic             out_c2_ff;

   bp12_pkg::stats_event_type evt;
   bp12_pkg::stats_count_type count;

   assign req_addr = EXT_W'(ADDRESS_BITS'(req_ch.payload.branch_address));
   assign req_idx  = req_addr[IDX_W-1:0];
   assign req_tag  = TAG_W'(req_addr >> IDX_W);

   assign s1_fire       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !clr_ff && (!s1_valid_ff || s1_fire);
   assign req_fire      = req_ch.valid && req_ch.ready;

   // The RAM returns old data when the previous item writes the same entry at
   // the edge of this read, so the last write is kept and forwarded.
   always_comb begin
      if (byp_valid_ff && byp_idx_ff == s1_idx_ff) begin
         cur = byp_data_ff;
      end else begin
         cur = entry_type'(ram_rd_data);
      end
   end

   always_comb begin
      hit = cur.valid && cur.tag == s1_tag_ff;
      p1  = hit && cur.last;
      p2  = hit && (cur.ctr >= bp12_pkg::CTR_WEAK_TAKEN);
      c1  = hit && (cur.last == s1_taken_ff);
      c2  = hit && ((cur.ctr >= bp12_pkg::CTR_WEAK_TAKEN) == s1_taken_ff);

      upd.valid = 1'b1;
      upd.tag   = s1_tag_ff;
      if (hit) begin
         upd.last = s1_taken_ff;
         if (s1_taken_ff) begin
            upd.ctr = (cur.ctr == bp12_pkg::CTR_STRONG_TAKEN) ? cur.ctr : cur.ctr + 2'd1;
         end else begin
            upd.ctr = (cur.ctr == bp12_pkg::CTR_STRONG_NOT_TAKEN) ? cur.ctr : cur.ctr - 2'd1;
         end
      end else begin
         upd.last = 1'b1;
         upd.ctr  = bp12_pkg::CTR_STRONG_NOT_TAKEN;
      end
   end

   always_comb begin
      if (clr_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_idx_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_fire;
         ram_wr_addr = s1_idx_ff;
         ram_wr_data = upd;
      end
   end

   bp12_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_idx),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (clr_ff) begin
            clr_idx_ff <= clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == LAST_IDX) begin
               clr_ff <= 1'b0;
            end
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (ram_wr_en) begin
            byp_valid_ff <= 1'b1;
         end
         if (s1_fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         s1_idx_ff   <= req_idx;
         s1_tag_ff   <= req_tag;
         s1_taken_ff <= req_ch.payload.outcome_taken;
      end
      if (ram_wr_en) begin
         byp_idx_ff  <= ram_wr_addr;
         byp_data_ff <= ram_wr_data;
      end
      if (s1_fire) begin
         out_known_ff <= hit;
         out_p1_ff    <= p1;
         out_p2_ff    <= p2;
         out_c1_ff    <= c1;
         out_c2_ff    <= c2;
      end
   end

   assign evt.fire        = s1_fire;
   assign evt.taken       = s1_taken_ff;
   assign evt.known       = hit;
   assign evt.correct_one = c1;
   assign evt.correct_two = c2;

   // The counters advance exactly when the response register loads, so they
   // serve directly as the response's count fields.
   bp12_stats u_stats (
      .clock (clock),
      .reset (reset),
      .evt   (evt),
      .count (count)
   );

   assign rsp_ch.valid                  = out_valid_ff;
   assign rsp_ch.payload.entry_known    = out_known_ff;
   assign rsp_ch.payload.predict_one    = out_p1_ff;
   assign rsp_ch.payload.predict_two    = out_p2_ff;
   assign rsp_ch.payload.correct_one    = out_c1_ff;
   assign rsp_ch.payload.correct_two    = out_c2_ff;
   assign rsp_ch.payload.branches_seen  = count.total;
   assign rsp_ch.payload.taken_seen     = count.taken;
   assign rsp_ch.payload.not_taken_seen = count.not_taken;
   assign rsp_ch.payload.hits_one       = count.hit_one;
   assign rsp_ch.payload.misses_one     = count.miss_one;
   assign rsp_ch.payload.hits_two       = count.hit_two;
   assign rsp_ch.payload.misses_two     = count.miss_two;

endmodule

`default_nettype wire

### sv/bp12_checker.sv
`default_nettype none

module bp12_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire bp12_pkg::rsp_type rsp_payload
);

   // The table clearing pass keeps requests out right after reset.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during table clearing");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.entry_known |->
         !rsp_payload.predict_one && !rsp_payload.predict_two &&
         !rsp_payload.correct_one && !rsp_payload.correct_two)
      else $error("prediction flags set on an unknown branch");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.branches_seen != '1 |->
         {1'b0, rsp_payload.taken_seen} + {1'b0, rsp_payload.not_taken_seen} ==
         {1'b0, rsp_payload.branches_seen})
      else $error("taken and not taken counts do not add up");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_payload.branches_seen != '1 |=>
         !rsp_valid ||
         rsp_payload.branches_seen == $past(rsp_payload.branches_seen) + 32'd1)
      else $error("branch count did not advance by one per response");

endmodule

bind branch_predictor_one_and_two_bit_core bp12_checker u_bp12_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

`default_nettype wire
